// ----- rtl/core/text_console_writer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define TCW_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, codes, shared types and cell helpers.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic REG_FORE_COLOR = 1'b0;
  localparam logic REG_BACK_COLOR = 1'b1;

  typedef struct packed {
    logic [3:0] fore;
    logic [3:0] back;
  } colors_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [15:0]      cell_value;
    logic [ROW_W-1:0] cursor_line;
    logic [COL_W-1:0] cursor_pos;
    logic             scrolled;
  } result_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] line,
                                                  input logic [COL_W-1:0] pos);
    cell_addr = ADDR_W'(line) * ADDR_W'(COLUMNS) + ADDR_W'(pos);
  endfunction

  function automatic logic [15:0] make_cell(input logic [7:0] ch, input colors_t c);
    make_cell = {c.back, c.fore, ch};
  endfunction

endpackage

// ----- rtl/core/tcw_screen_ram.sv -----
// ----------------------------------------------------------------------------
// Text console screen memory
// One write port and one read port; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
  input  logic              clk_i,
  input  tcw_pkg::ram_req_t req_i,
  output logic [15:0]       rdata_o
);
  import tcw_pkg::*;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tcw_seq.sv -----
// ----------------------------------------------------------------------------
// Text console sequencer
// Cursor state and the walks over screen memory for fill, scroll and clear.
// ----------------------------------------------------------------------------
`include "text_console_writer_top_assert.svh"

module tcw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcw_pkg::colors_t    colors_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          character_i,
  input  logic [4:0]          cell_row_i,
  input  logic [6:0]          cell_col_i,
  output tcw_pkg::ram_req_t   ram_req_o,
  input  logic [15:0]         rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tcw_pkg::result_t    res_o
);
  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_FILL       = 3'd1;
  localparam logic [2:0] S_ADV        = 3'd2;
  localparam logic [2:0] S_SCROLL     = 3'd3;
  localparam logic [2:0] S_SCROLL_END = 3'd4;
  localparam logic [2:0] S_PUT        = 3'd5;
  localparam logic [2:0] S_DONE       = 3'd6;

  localparam logic [1:0] FM_EOL   = 2'd0;
  localparam logic [1:0] FM_LAST  = 2'd1;
  localparam logic [1:0] FM_CLEAR = 2'd2;

  localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_LINE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

  logic [2:0]        state_q, state_d;
  logic [1:0]        fmode_q, fmode_d;
  logic [ROW_W-1:0]  line_q, line_d;
  logic [COL_W-1:0]  pos_q, pos_d;
  logic              put_after_q, put_after_d;
  logic              scrolled_q, scrolled_d;
  logic              rd_ok_q, rd_ok_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [ADDR_W-1:0] waddr_q, waddr_d;
  logic [7:0]        char_q, char_d;
  logic [15:0]       blank;

  assign blank = make_cell(CH_SPACE, colors_i);

  always_comb begin
    state_d     = state_q;
    fmode_d     = fmode_q;
    line_d      = line_q;
    pos_d       = pos_q;
    put_after_d = put_after_q;
    scrolled_d  = scrolled_q;
    rd_ok_d     = rd_ok_q;
    pend_d      = 1'b0;
    addr_d      = addr_q;
    last_d      = last_q;
    waddr_d     = waddr_q;
    char_d      = char_q;
    ram_req_o   = '0;

    // The copy pipeline writes back what it read in the previous cycle.
    if (pend_q) begin
      ram_req_o.we    = 1'b1;
      ram_req_o.waddr = waddr_q;
      ram_req_o.wdata = rdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          scrolled_d  = 1'b0;
          rd_ok_d     = 1'b0;
          put_after_d = 1'b0;
          char_d      = character_i;
          unique case (op_i)
            OP_PUT: begin
              if (character_i == CH_NUL) begin
                state_d = S_DONE;
              end else if (character_i == CH_NEWLINE) begin
                if (pos_q < COL_W'(COLUMNS)) begin
                  addr_d  = cell_addr(line_q, pos_q);
                  last_d  = cell_addr(line_q, COL_W'(COLUMNS - 1));
                  fmode_d = FM_EOL;
                  state_d = S_FILL;
                end else begin
                  state_d = S_ADV;
                end
              end else if (pos_q == COL_W'(COLUMNS)) begin
                put_after_d = 1'b1;
                state_d     = S_ADV;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = cell_addr(line_q, pos_q);
                ram_req_o.wdata = make_cell(character_i, colors_i);
                pos_d           = pos_q + COL_W'(1);
                state_d         = S_DONE;
              end
            end
            OP_CLEAR: begin
              addr_d  = '0;
              last_d  = LAST_CELL;
              fmode_d = FM_CLEAR;
              state_d = S_FILL;
            end
            OP_READ: begin
              if ((cell_row_i < ROW_W'(ROWS)) && (cell_col_i < COL_W'(COLUMNS))) begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = cell_addr(cell_row_i, cell_col_i);
                rd_ok_d         = 1'b1;
              end
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_FILL: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = addr_q;
        ram_req_o.wdata = blank;
        if (addr_q == last_q) begin
          unique case (fmode_q)
            FM_EOL:  state_d = S_ADV;
            FM_LAST: state_d = put_after_q ? S_PUT : S_DONE;
            default: state_d = S_DONE;
          endcase
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      S_ADV: begin
        pos_d = '0;
        if (line_q == ROW_W'(ROWS - 1)) begin
          scrolled_d = 1'b1;
          addr_d     = '0;
          state_d    = S_SCROLL;
        end else begin
          line_d  = line_q + ROW_W'(1);
          state_d = put_after_q ? S_PUT : S_DONE;
        end
      end
      S_SCROLL: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = addr_q + ADDR_W'(COLUMNS);
        pend_d          = 1'b1;
        waddr_d         = addr_q;
        if (addr_q == LAST_COPY) begin
          state_d = S_SCROLL_END;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      S_SCROLL_END: begin
        addr_d  = LAST_LINE;
        last_d  = LAST_CELL;
        fmode_d = FM_LAST;
        state_d = S_FILL;
      end
      S_PUT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cell_addr(line_q, pos_q);
        ram_req_o.wdata = make_cell(char_q, colors_i);
        pos_d           = pos_q + COL_W'(1);
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fmode_q     <= FM_EOL;
      line_q      <= '0;
      pos_q       <= '0;
      put_after_q <= 1'b0;
      scrolled_q  <= 1'b0;
      rd_ok_q     <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fmode_q     <= fmode_d;
      line_q      <= line_d;
      pos_q       <= pos_d;
      put_after_q <= put_after_d;
      scrolled_q  <= scrolled_d;
      rd_ok_q     <= rd_ok_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    last_q  <= last_d;
    waddr_q <= waddr_d;
    char_q  <= char_d;
  end

  assign in_ready_o             = (state_q == S_IDLE);
  assign res_valid_o            = (state_q == S_DONE);
  assign res_o.cell_value       = rd_ok_q ? rdata_i : 16'h0000;
  assign res_o.cursor_line      = line_q;
  assign res_o.cursor_pos       = pos_q;
  assign res_o.scrolled         = scrolled_q;

  `TCW_NEVER(a_cursor_range, (pos_q > COL_W'(COLUMNS)) || (line_q > ROW_W'(ROWS - 1)), "cursor out of range")
  `TCW_NEVER(a_copy_order, pend_q && ram_req_o.re && (ram_req_o.raddr <= waddr_q), "scroll read behind write")
  `TCW_NEVER(a_write_range, ram_req_o.we && (ram_req_o.waddr > LAST_CELL), "write beyond screen")
  `TCW_ASSERT(a_accept_busy, (in_valid_i && (state_q == S_IDLE)) |=> (state_q != S_IDLE), "request not taken")

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen of coloured cells with a cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Work per request: a printable character, a NUL or a read needs no memory walk;
// a newline also blanks the rest of the cursor line, and a wrap steps down a line.
// A scroll copies the screen up one line and blanks the last line, and a clear
// blanks every cell; these walks cover one cell per cycle. A new request is
// taken only once the previous one has left the sequencer.
// Reset: cursor top left, colours light grey on black; screen undefined until a clear.

module text_console_writer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration writes
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [3:0] cfg_data_i,
  // Request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] character_i,
  input  logic [4:0] cell_row_i,
  input  logic [6:0] cell_col_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [15:0] cell_value_o,
  output logic [4:0] cursor_line_o,
  output logic [6:0] cursor_pos_o,
  output logic       scrolled_o
);
  import tcw_pkg::*;

  // Colour registers. Software is to write them only while the block is idle, so
  // the sequencer can use them directly; the block itself does not enforce this.
  colors_t colors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q.fore <= 4'd7;
      colors_q.back <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FORE_COLOR: colors_q.fore <= cfg_data_i;
        REG_BACK_COLOR: colors_q.back <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ram_req_t    ram_req;
  logic [15:0] ram_rdata;
  logic        res_valid;
  logic        res_ready;
  result_t     res;

  // The sequencer owns the cursor and drives every memory access: single writes
  // for characters, single reads for cell reads, and address walks for newline
  // blanking, the scroll copy (read one line down, write back next cycle) and clear.
  tcw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .colors_i    (colors_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .character_i (character_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .ram_req_o   (ram_req),
    .rdata_i     (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Output register. It parts the two sides, so the next request can be
  // taken and worked on while the previous result waits to be collected.
  logic    out_valid_q;
  result_t out_q;

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_value_o  = out_q.cell_value;
  assign cursor_line_o = out_q.cursor_line;
  assign cursor_pos_o  = out_q.cursor_pos;
  assign scrolled_o    = out_q.scrolled;

endmodule

// ----- tb/sv/tb_text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put, clear, read and unused requests through the request channel.
// Each request's result is predicted from a private image of the screen,
// the cursor and the colours, and every result is compared field by field.
// Both channels idle and stall at random. The colours are rewritten between
// phases.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
  import tcw_pkg::*;

  // The fourth op code has no function and must leave everything alone.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // A clear or a scroll walks the whole screen memory, so the quiet limit
  // allows several of them on top of the longest receiver hold-off.
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = CELLS + 200;
  localparam int PHASE_ITEMS   = 500;
  localparam int HOLD_CYCLES   = 600;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [7:0]  character_i;
  logic [4:0]  cell_row_i;
  logic [6:0]  cell_col_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] cell_value_o;
  logic [4:0]  cursor_line_o;
  logic [6:0]  cursor_pos_o;
  logic        scrolled_o;

  text_console_writer_top dut (.*);

  // Private image of the block: screen cells, which cells hold defined data,
  // cursor and colours. It is updated at the edge where a request is taken.
  logic [15:0] screen_image [CELLS];
  bit          screen_known [CELLS];
  int unsigned cursor_row = 0;
  int unsigned cursor_col = 0;
  logic [3:0]  fore_nibble = 4'd7;
  logic [3:0]  back_nibble = 4'd0;

  // Results still owed by the block, oldest first.
  result_t awaited_reports [$];

  // Idling percentages for each side; the receiver's hold-off is handed to
  // its process through hold_request and counted there in hold_left.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;
  int hold_left          = 0;

  // Printable characters still to come before the random stream's next newline.
  int line_budget = 0;

  int errors          = 0;
  int requests_sent   = 0;
  int reads_sent      = 0;
  int clears_sent     = 0;
  int scrolls_seen    = 0;
  int wraps_seen      = 0;
  int results_checked = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [15:0] coloured_cell(logic [7:0] ch);
    return {back_nibble, fore_nibble, ch};
  endfunction

  // Blanks the rest of the cursor line and steps down one line. Past the
  // bottom line the whole image moves up one line and the last line is
  // blanked. Returns 1 when the image scrolled.
  function automatic bit step_down_line();
    logic [15:0] blank;
    int i;
    blank = coloured_cell(CH_SPACE);
    while (cursor_col < COLUMNS) begin
      screen_image[cursor_row * COLUMNS + cursor_col] = blank;
      screen_known[cursor_row * COLUMNS + cursor_col] = 1'b1;
      cursor_col++;
    end
    cursor_row++;
    cursor_col = 0;
    if (cursor_row < ROWS) return 1'b0;
    for (i = 0; i < CELLS - COLUMNS; i++) begin
      screen_image[i] = screen_image[i + COLUMNS];
      screen_known[i] = screen_known[i + COLUMNS];
    end
    for (i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen_image[i] = blank;
      screen_known[i] = 1'b1;
    end
    cursor_row = ROWS - 1;
    return 1'b1;
  endfunction

  // Applies one request to the image and returns the result it must give.
  function automatic result_t console_report(logic [1:0] op, logic [7:0] ch,
                                             logic [4:0] row, logic [6:0] col);
    result_t r;
    int i;
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch != CH_NUL) begin
          if (cursor_row >= ROWS) cursor_row = 0;
          if (cursor_col > COLUMNS) cursor_col = COLUMNS;
          if (ch == CH_NEWLINE) begin
            r.scrolled = step_down_line();
          end else begin
            // A pending wrap is taken first, then the character is written.
            if (cursor_col >= COLUMNS) begin
              r.scrolled = step_down_line();
              wraps_seen++;
            end
            screen_image[cursor_row * COLUMNS + cursor_col] = coloured_cell(ch);
            screen_known[cursor_row * COLUMNS + cursor_col] = 1'b1;
            cursor_col++;
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) begin
          screen_image[i] = coloured_cell(CH_SPACE);
          screen_known[i] = 1'b1;
        end
      end
      OP_READ: begin
        if (row < ROWS && col < COLUMNS) r.cell_value = screen_image[row * COLUMNS + col];
      end
      default: begin
      end
    endcase
    r.cursor_line = cursor_row[4:0];
    r.cursor_pos  = cursor_col[6:0];
    if (r.scrolled) scrolls_seen++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request, waits until it is taken, records its expected result
  // and then perhaps idles. Valid is left high when no idle gap follows, so
  // the next request follows on without a bubble.
  task automatic send_request(logic [1:0] op, logic [7:0] ch,
                              logic [4:0] row, logic [6:0] col);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    character_i <= ch;
    cell_row_i  <= row;
    cell_col_i  <= col;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_reports.push_back(console_report(op, ch, row, col));
    requests_sent++;
    if (op == OP_READ) reads_sent++;
    if (op == OP_CLEAR) clears_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic stop_offering();
    if (in_valid_i) in_valid_i <= 1'b0;
  endtask

  // Waits until every owed result has come back and the block takes requests
  // again, so that it has no work left in flight.
  task automatic wait_until_drained();
    stop_offering();
    while (awaited_reports.size() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Writes both colour registers on back-to-back cycles while idle.
  task automatic set_colours(logic [3:0] fore, logic [3:0] back);
    wait_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FORE_COLOR;
    cfg_data_i  <= fore;
    @(posedge clk_i);
    cfg_index_i <= REG_BACK_COLOR;
    cfg_data_i  <= back;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    fore_nibble = fore;
    back_nibble = back;
  endtask

  function automatic logic [7:0] random_glyph();
    logic [7:0] g;
    do g = 8'($urandom_range(1, 255)); while (g == CH_NEWLINE);
    return g;
  endfunction

  // Sends printable characters until the cursor reports a pending wrap.
  task automatic fill_line();
    while (cursor_col < COLUMNS) send_request(OP_PUT, random_glyph(), 5'd0, 7'd0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: checking, receiver stalls and the long hold-off
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (errors < 100)
      $display("ERROR %0t: %s is %h, should be %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_reports.size() == 0) begin
          report_mismatch("result with nothing owed, cell_value", cell_value_o, 16'h0);
        end else begin
          want = awaited_reports.pop_front();
          results_checked++;
          if (cell_value_o !== want.cell_value)
            report_mismatch("cell_value", cell_value_o, want.cell_value);
          if (cursor_line_o !== want.cursor_line)
            report_mismatch("cursor_line", 16'(cursor_line_o), 16'(want.cursor_line));
          if (cursor_pos_o !== want.cursor_pos)
            report_mismatch("cursor_pos", 16'(cursor_pos_o), 16'(want.cursor_pos));
          if (scrolled_o !== want.scrolled)
            report_mismatch("scrolled", 16'(scrolled_o), 16'(want.scrolled));
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // The run ends when neither channel has moved a request for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no request moved for %0d cycles, %0d results owed",
             QUIET_LIMIT, awaited_reports.size());
    $display("text_console_writer_top: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the cursor sits at the top left. Only cells written since
  // reset are read back before the first clear.
  task automatic test_reset_state();
    send_request(OP_PUT, CH_NUL, 5'd31, 7'd127);
    send_request(OP_SPARE, 8'hFF, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'd31, 7'd127);
    send_request(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_request(OP_READ, 8'hFF, 5'(ROWS - 1), 7'(COLUMNS - 1));
  endtask

  // Colour and byte extremes, and reads just outside the screen.
  task automatic test_colours_and_bytes();
    set_colours(4'hF, 4'hF);
    send_request(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_request(OP_PUT, 8'h01, 5'd0, 7'd0);
    send_request(OP_PUT, 8'h80, 5'd0, 7'd0);
    send_request(OP_PUT, 8'h7F, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'd0, 7'd1);
    send_request(OP_READ, 8'h00, 5'd0, 7'd4);
    set_colours(4'h0, 4'h0);
    send_request(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'd0, 7'(COLUMNS - 1));
    send_request(OP_READ, 8'h00, 5'd0, 7'(COLUMNS));
    send_request(OP_READ, 8'h00, 5'(ROWS), 7'd0);
    send_request(OP_PUT, CH_NUL, 5'd0, 7'd0);
  endtask

  // A full line leaves a wrap pending. A printable character then wraps and
  // is written at the start of the next line; a newline moves down just once.
  task automatic test_line_wrap();
    set_colours(4'h7, 4'h0);
    send_request(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
    fill_line();
    send_request(OP_PUT, 8'h57, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'(cursor_row), 7'd0);
    send_request(OP_READ, 8'h00, 5'(cursor_row - 1), 7'(COLUMNS - 1));
    fill_line();
    send_request(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'(cursor_row - 1), 7'd0);
  endtask

  // Enough newlines to push the cursor past the bottom line several times.
  task automatic test_scroll();
    send_request(OP_PUT, 8'h53, 5'd0, 7'd0);
    repeat (ROWS + 3) send_request(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'(ROWS - 5), 7'd0);
    send_request(OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1));
    fill_line();
    send_request(OP_PUT, 8'h2A, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'(ROWS - 2), 7'd3);
  endtask

  // One random request. Most of the stream is lines of text of random
  // length ended by a newline; some lines run to exactly the last column or
  // beyond, so that wraps and newlines after a full line both occur.
  task automatic send_random_request();
    int roll;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    roll = $urandom_range(99);
    row  = 5'($urandom_range(31));
    col  = 7'($urandom_range(127));
    ch   = 8'($urandom_range(255));
    if (roll < 1) begin
      send_request(OP_CLEAR, ch, row, col);
    end else if (roll < 3) begin
      send_request(OP_PUT, CH_NUL, row, col);
    end else if (roll < 5) begin
      send_request(OP_SPARE, ch, row, col);
    end else if (roll < 25) begin
      case ($urandom_range(3))
        0: begin
          row = 5'(cursor_row);
          col = 7'($urandom_range(COLUMNS - 1));
        end
        1: begin
          row = 5'($urandom_range(ROWS - 1));
          col = 7'($urandom_range(COLUMNS - 1));
        end
        2: begin
          row = 5'($urandom_range(31, ROWS));
        end
        default: begin
          row = 5'($urandom_range(ROWS - 1));
          col = 7'($urandom_range(127, COLUMNS));
        end
      endcase
      // Never read a cell that holds nothing defined yet.
      if (row < ROWS && col < COLUMNS && !screen_known[row * COLUMNS + col])
        row = 5'($urandom_range(31, ROWS));
      send_request(OP_READ, ch, row, col);
    end else if (line_budget > 0) begin
      line_budget--;
      send_request(OP_PUT, random_glyph(), row, col);
    end else begin
      send_request(OP_PUT, CH_NEWLINE, row, col);
      case ($urandom_range(7))
        0: line_budget = COLUMNS;
        1: line_budget = $urandom_range(2 * COLUMNS, COLUMNS - 10);
        default: line_budget = $urandom_range(30);
      endcase
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct,
                                   logic [3:0] fore, logic [3:0] back);
    set_colours(fore, back);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_random_request();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block fills up and stops taking requests until results drain.
  task automatic test_receiver_hold_off();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = HOLD_CYCLES;
    repeat (40) send_random_request();
  endtask

  // The sender pauses until every owed result is back, then carries on.
  task automatic test_sender_pause();
    sender_idle_pct    = 0;
    receiver_stall_pct = 30;
    repeat (15) send_random_request();
    wait_until_drained();
    repeat (15) send_random_request();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_FORE_COLOR;
    cfg_data_i  <= 4'd0;
    in_valid_i  <= 1'b0;
    op_i        <= OP_PUT;
    character_i <= CH_NUL;
    cell_row_i  <= 5'd0;
    cell_col_i  <= 7'd0;
    out_ready_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_colours_and_bytes();
    test_line_wrap();
    test_scroll();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_phase(0, 0, 4'($urandom_range(15)), 4'($urandom_range(15)));
    test_random_phase(84, 0, 4'hF, 4'hF);
    test_random_phase(0, 84, 4'h0, 4'h0);
    test_random_phase(6, 6, 4'($urandom_range(15)), 4'($urandom_range(15)));

    // Let any stray work finish; a result that turns up now is unexpected.
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_reports.size() != 0)
      report_mismatch("results never delivered", 16'(awaited_reports.size()), 16'h0);

    $display("Run covered %0d requests: %0d reads, %0d clears, %0d scrolls, %0d wraps.",
             requests_sent, reads_sent, clears_sent, scrolls_seen, wraps_seen);
    $display("%0d results were checked, %0d field errors found.", results_checked, errors);
    if (errors == 0) begin
      $display("text_console_writer_top: match");
    end else begin
      $display("text_console_writer_top: mismatch");
    end
    $finish;
  end

endmodule
